[hdl/deq_pkg.sv]
package deq_pkg;

	// queue geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// payload field widths
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int READ_W   = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_POP_BACK   = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_PUSH_FRONT = 3'd3,
		OP_READ_INDEX = 3'd4,
		OP_REMOVE     = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// ring position of front plus offset, offset at most DEPTH - 1
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
			input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, ptr} + {1'b0, off};
		if (sum >= (PTR_W + 1)'(DEPTH)) begin
			sum = sum - (PTR_W + 1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

[hdl/deq_in_if.sv]
interface deq_in_if;
	import deq_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [VALUE_W-1:0] value;
	logic [INDEX_W-1:0] index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink (input valid, input op, input value, input index, output ready);

endinterface

[hdl/deq_out_if.sv]
interface deq_out_if;
	import deq_pkg::*;

	logic                valid;
	logic                ready;
	logic [READ_W-1:0]   read_value;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output read_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input read_value, input status, input occupancy,
		output ready);

endinterface

[hdl/deq_ram.sv]
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/double_ended_queue_engine.sv]
// double-ended queue engine
//
// req channel: one beat per operation (op, value, index). ops are push back,
// pop back, pop front, push front, read at index from the front, and remove
// the first entry equal to value, closing the gap toward the front.
// rsp channel: one beat per request with read_value, status and occupancy
// (entry count after the operation). read_value is zero unless status is ok.
//
// path from request beat to response valid, with rsp not stalled:
//   pushes, errors, unused op codes: straight to the finish state
//   pops and index reads: one ring ram read (registered), then finish
//   remove: a search state reads from the front up to the match position,
//   one ram read per cycle; a compaction state then does one read and one
//   write per cycle up to the last entry. no match goes from search to finish
// a new request is taken the cycle after a response loads, so only one
// operation is worked at a time.
// reset empties the queue (front and count cleared); ram contents are left
// as they are, since only entries inside the count are ever read.
// a stalled rsp holds its beat in the output register; the next request is
// still taken and worked, and its response waits in the finish state.
module double_ended_queue_engine (
	input logic clk,
	input logic arst_n,
	deq_in_if.sink   req,
	deq_out_if.source rsp
);
	import deq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RD    = 5'b00010,
		S_SRCH  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// control state
	state_t           state_q, state_d;
	logic [PTR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             out_valid_q;

	// per-request working registers
	logic [DATA_WIDTH-1:0] word_q, word_d;
	logic [DATA_WIDTH-1:0] res_word_q, res_word_d;
	status_t               res_status_q, res_status_d;

	// response register payload
	logic [DATA_WIDTH-1:0] out_word_q;
	status_t               out_status_q;
	logic [CNT_W-1:0]      out_occ_q;

	// ring ram port
	logic                  mem_we;
	logic [PTR_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [PTR_W-1:0]      mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	logic                  load_out;
	logic                  full;
	logic                  empty;
	logic [DATA_WIDTH-1:0] word_in;
	logic [CNT_W-1:0]      idx_inc;
	logic [CNT_W:0]        idx_inc2;

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign word_in  = DATA_WIDTH'(req.value);
	assign idx_inc  = idx_q + CNT_W'(1);
	assign idx_inc2 = {1'b0, idx_q} + (CNT_W + 1)'(2);

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		idx_d        = idx_q;
		word_d       = word_q;
		res_word_d   = res_word_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = front_q;
		mem_wdata    = word_in;
		mem_raddr    = front_q;
		load_out     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					word_d       = word_in;
					res_word_d   = '0;
					res_status_d = ST_OK;
					state_d      = S_DONE;
					case (op_t'(req.op))
						OP_PUSH_BACK: begin
							if (full) begin
								res_status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = ring_add(front_q, PTR_W'(count_q));
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_PUSH_FRONT: begin
							if (full) begin
								res_status_d = ST_FULL;
							end else begin
								// front steps back one place around the ring
								front_d   = ring_add(front_q, PTR_W'(DEPTH - 1));
								mem_we    = 1'b1;
								mem_waddr = front_d;
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								res_status_d = ST_EMPTY;
							end else begin
								mem_raddr = ring_add(front_q, PTR_W'(count_q - CNT_W'(1)));
								count_d   = count_q - CNT_W'(1);
								state_d   = S_RD;
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								res_status_d = ST_EMPTY;
							end else begin
								mem_raddr = front_q;
								front_d   = ring_add(front_q, PTR_W'(1));
								count_d   = count_q - CNT_W'(1);
								state_d   = S_RD;
							end
						end
						OP_READ_INDEX: begin
							if (32'(req.index) >= 32'(count_q)) begin
								res_status_d = ST_RANGE;
							end else begin
								mem_raddr = ring_add(front_q, PTR_W'(req.index));
								state_d   = S_RD;
							end
						end
						OP_REMOVE: begin
							if (empty) begin
								res_status_d = ST_NOTFOUND;
							end else begin
								// search starts at the front entry
								mem_raddr = front_q;
								idx_d     = '0;
								state_d   = S_SRCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				res_word_d = mem_rdata;
				state_d    = S_DONE;
			end
			S_SRCH: begin
				// rdata holds entry idx; fetch idx + 1 for either path
				mem_raddr = ring_add(front_q, PTR_W'(idx_inc));
				if (mem_rdata == word_q) begin
					res_word_d = mem_rdata;
					if (idx_inc >= count_q) begin
						// match on the last entry, nothing to move
						count_d = count_q - CNT_W'(1);
						state_d = S_DONE;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (idx_inc >= count_q) begin
					res_status_d = ST_NOTFOUND;
					state_d      = S_DONE;
				end else begin
					idx_d = idx_inc;
				end
			end
			S_SHIFT: begin
				// rdata holds entry idx + 1, moved down into idx
				mem_we    = 1'b1;
				mem_waddr = ring_add(front_q, PTR_W'(idx_q));
				mem_wdata = mem_rdata;
				mem_raddr = ring_add(front_q, PTR_W'(idx_inc2));
				idx_d     = idx_inc;
				if (idx_inc2 >= {1'b0, count_q}) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the response register to free up
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q       <= word_d;
		res_word_q   <= res_word_d;
		res_status_q <= res_status_d;
		if (load_out) begin
			out_word_q   <= res_word_q;
			out_status_q <= res_status_q;
			out_occ_q    <= count_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = READ_W'(out_word_q);
	assign rsp.status     = STATUS_W'(out_status_q);
	assign rsp.occupancy  = OCC_W'(out_occ_q);

	// count never passes the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// search index stays inside the held entries
	a_srch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_SHIFT) |-> idx_q < count_q)
		else $error("remove index outside the queue");

	// compaction never reads the entry it is overwriting when the data is used
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && idx_inc2 < {1'b0, count_q}) |-> mem_waddr != mem_raddr)
		else $error("compaction read and write collide");

	// a successful pop from the back takes exactly one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.op == OP_W'(OP_POP_BACK) && !empty)
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not decrement count");

	// a response beat only appears out of the finish state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !$past(rsp.valid && !rsp.ready)) |-> $past(state_q == S_DONE))
		else $error("response loaded outside finish state");

endmodule

[sim/testbench.sv]
module testbench;
	import deq_pkg::*;

	// codes outside the defined op set, which the engine must ignore
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// stimulus mix for the random part
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	// settle tail after the last response, with room for a full-depth remove
	localparam int DRAIN_TAIL  = 100;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 370;

	typedef struct packed {
		logic [READ_W-1:0] read_value;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} rsp_beat_t;

	// mirror of the ring, front and count; predicts one response beat per request
	class deque_mirror;
		logic [DATA_WIDTH-1:0] ring [DEPTH];
		logic [PTR_W-1:0]      front;
		logic [CNT_W-1:0]      count;
		rsp_beat_t             awaited [$];
		int                    failures;

		function new();
			front    = '0;
			count    = '0;
			failures = 0;
		endfunction

		function logic [PTR_W-1:0] slot(int off);
			return PTR_W'((int'(front) + off) % DEPTH);
		endfunction

		function int held();
			return int'(count);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function logic [DATA_WIDTH-1:0] entry(int pos);
			return ring[slot(pos)];
		endfunction

		function void record_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
				logic [INDEX_W-1:0] index);
			rsp_beat_t beat;
			int        hit;
			int        i;
			beat.read_value = '0;
			beat.status     = ST_OK;
			case (op)
				OP_PUSH_BACK: begin
					if (count == DEPTH) begin
						beat.status = ST_FULL;
					end else begin
						ring[slot(count)] = value;
						count++;
					end
				end
				OP_POP_BACK: begin
					if (count == 0) begin
						beat.status = ST_EMPTY;
					end else begin
						beat.read_value = ring[slot(count - 1)];
						count--;
					end
				end
				OP_POP_FRONT: begin
					if (count == 0) begin
						beat.status = ST_EMPTY;
					end else begin
						beat.read_value = ring[slot(0)];
						front = slot(1);
						count--;
					end
				end
				OP_PUSH_FRONT: begin
					if (count == DEPTH) begin
						beat.status = ST_FULL;
					end else begin
						front = slot(DEPTH - 1);
						ring[front] = value;
						count++;
					end
				end
				OP_READ_INDEX: begin
					if (index >= count) begin
						beat.status = ST_RANGE;
					end else begin
						beat.read_value = ring[slot(index)];
					end
				end
				OP_REMOVE: begin
					hit = -1;
					for (i = 0; i < count; i++) begin
						if (ring[slot(i)] == value) begin
							hit = i;
							break;
						end
					end
					if (hit < 0) begin
						beat.status = ST_NOTFOUND;
					end else begin
						beat.read_value = ring[slot(hit)];
						for (i = hit; i + 1 < count; i++) begin
							ring[slot(i)] = ring[slot(i + 1)];
						end
						count--;
					end
				end
				default: begin
				end
			endcase
			beat.occupancy = count;
			awaited.push_back(beat);
		endfunction

		function void compare_response(logic [READ_W-1:0] read_value,
				logic [STATUS_W-1:0] status, logic [OCC_W-1:0] occupancy);
			rsp_beat_t want;
			if (awaited.size() == 0) begin
				$error("response beat with none outstanding: read_value %h status %0d occupancy %0d",
					read_value, status, occupancy);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (read_value !== want.read_value) begin
				$error("read_value: expected %h, got %h", want.read_value, read_value);
				failures++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				failures++;
			end
			if (occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle;
	int   sink_idle;
	int   quiet;

	deque_mirror mirror;

	deq_in_if  req_ch ();
	deq_out_if rsp_ch ();

	double_ended_queue_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: ready changes at the falling edge, idling at sink_idle percent
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle);
	end

	// both monitors sample at the rising edge; a request is predicted as it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				mirror.record_request(req_ch.op, req_ch.value, req_ch.index);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				mirror.compare_response(rsp_ch.read_value, rsp_ch.status, rsp_ch.occupancy);
			end
		end
	end

	// watchdog: too long with no beat on either channel means the engine hung
	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// one request beat; called at a falling edge, returns at the falling edge after the beat
	task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			input logic [INDEX_W-1:0] index);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= value;
		req_ch.index <= index;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// sender holds off until every response is back, then lets the engine settle
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (mirror.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_TAIL) @(posedge clk);
		@(negedge clk);
	endtask

	// words from a small pool give duplicates, so remove has to find the first one
	function automatic logic [VALUE_W-1:0] pick_word();
		if ($urandom_range(99) < 40) begin
			case ($urandom_range(7))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return VALUE_W'($urandom_range(5, 1));
			endcase
		end
		return $urandom;
	endfunction

	task automatic make_request(input int mix, output logic [OP_W-1:0] op,
			output logic [VALUE_W-1:0] value, output logic [INDEX_W-1:0] index);
		int push_at, pop_at, read_at, remove_at;
		int roll;
		int depth_now;
		depth_now = mirror.held();
		case (mix)
			MIX_FILL: begin
				push_at = 60; pop_at = 70; read_at = 80; remove_at = 97;
			end
			MIX_DRAIN: begin
				push_at = 15; pop_at = 65; read_at = 80; remove_at = 97;
			end
			default: begin
				push_at = 30; pop_at = 55; read_at = 75; remove_at = 97;
			end
		endcase
		roll  = $urandom_range(99);
		value = pick_word();
		index = INDEX_W'($urandom_range(63));
		if (roll < push_at) begin
			op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end else if (roll < pop_at) begin
			op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		end else if (roll < read_at) begin
			op = OP_READ_INDEX;
			if (depth_now > 0 && $urandom_range(4) != 0) begin
				index = INDEX_W'($urandom_range(depth_now - 1));
			end
		end else if (roll < remove_at) begin
			op = OP_REMOVE;
			if (depth_now > 0 && $urandom_range(3) != 0) begin
				value = mirror.entry($urandom_range(depth_now - 1));
			end
		end else begin
			op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
		end
	endtask

	// random part in episodes, each leaning toward filling, draining or neither
	task automatic run_random(input int items);
		int mix;
		int left;
		int k;
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
		left = 0;
		mix  = MIX_EVEN;
		for (k = 0; k < items; k++) begin
			if (left == 0) begin
				mix  = $urandom_range(2);
				left = $urandom_range(120, 20);
			end
			left--;
			make_request(mix, op, value, index);
			send_request(op, value, index);
		end
	endtask

	task automatic run_directed();
		// everything on an empty queue fails or is ignored
		send_request(OP_POP_BACK, '1, '1);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_READ_INDEX, '0, '0);
		send_request(OP_REMOVE, '0, '0);
		send_request(OP_SPARE_LO, '1, '1);
		send_request(OP_SPARE_HI, '1, '1);
		// both ends, extreme words
		send_request(OP_PUSH_BACK, '0, '0);
		send_request(OP_PUSH_BACK, '1, '1);
		send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5, '0);
		send_request(OP_PUSH_FRONT, 32'h5A5A_5A5A, '1);
		send_request(OP_READ_INDEX, '0, 6'd0);
		send_request(OP_READ_INDEX, '0, 6'd3);
		send_request(OP_READ_INDEX, '0, 6'd4);
		send_request(OP_READ_INDEX, '1, 6'd63);
		send_request(OP_SPARE_HI, 32'h1234_5678, 6'd2);
		// match on the very first entry, then on the last entry, then no match
		send_request(OP_REMOVE, 32'h5A5A_5A5A, '0);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_REMOVE, 32'h1234_5678, '0);
		send_request(OP_READ_INDEX, '0, 6'd1);
		send_request(OP_POP_BACK, '0, '0);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_POP_BACK, '0, '0);
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = '0;
		req_ch.value  = '0;
		req_ch.index  = '0;
		rsp_ch.ready  = 1'b0;
		src_idle      = 31;
		sink_idle     = 55;
		mirror        = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(PHASE_ITEMS);
		wait_for_drain();

		src_idle  = 55;
		sink_idle = 31;
		run_random(PHASE_ITEMS);
		wait_for_drain();

		// full rate on both sides
		src_idle  = 0;
		sink_idle = 0;
		run_random(PHASE_ITEMS);
		wait_for_drain();

		if (mirror.failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
